@@ hw/rtl/psc_pkg.sv @@
// Package: shared types and constants for the pose settle controller.
package psc_pkg;

	localparam int CounterWidthDef = 16;
	localparam int PositionWidthDef = 24;

	localparam logic [1:0] OP_TICK = 2'd0;
	localparam logic [1:0] OP_POSE = 2'd1;
	localparam logic [1:0] OP_HEAD = 2'd2;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	localparam logic [1:0] MODE_TELEOP = 2'd0;
	localparam logic [1:0] MODE_HEAD = 2'd1;
	localparam logic [1:0] MODE_AUTO = 2'd2;

	localparam logic [2:0] REG_X_GAIN = 3'd0;
	localparam logic [2:0] REG_Y_GAIN = 3'd1;
	localparam logic [2:0] REG_H_GAIN = 3'd2;
	localparam logic [2:0] REG_L_STATIC = 3'd3;
	localparam logic [2:0] REG_H_STATIC = 3'd4;
	localparam logic [2:0] REG_L_TOL = 3'd5;
	localparam logic [2:0] REG_H_TOL = 3'd6;
	localparam logic [2:0] REG_SETTLE = 3'd7;

	typedef struct packed {
		logic [1:0] op;
		logic enabled;
		logic autonomous;
		logic signed [23:0] pos_x;
		logic signed [23:0] pos_y;
		logic signed [23:0] pos_yaw;
		logic signed [23:0] goal_x;
		logic signed [23:0] goal_y;
		logic signed [23:0] goal_heading;
	} in_item_t;

	typedef struct packed {
		logic drive_valid;
		logic signed [15:0] drive_x;
		logic signed [15:0] drive_y;
		logic signed [15:0] drive_turn;
		logic goal_reached;
		logic [1:0] mode_now;
	} out_item_t;

	function automatic logic signed [15:0] sat16(input logic signed [42:0] v);
		if (v > 43'sd32767) return 16'sh7fff;
		if (v < -43'sd32768) return 16'sh8000;
		return v[15:0];
	endfunction

endpackage

@@ hw/rtl/pose_settle_controller_unit.sv @@
// Top level: pose settle controller with a shared multiplier and serial divider.
// Set operations go straight to the output. A control tick forms the errors, runs the
// shared multiplier per axis and forms the commands; unless the goal is reached it then
// updates the settle counters, with a serial divide of COUNTER_WIDTH+17 steps when the
// heading counter advances. One item at a time: ready is low while an item is in work.
// The result waits in an output register; a new item is taken alongside it.
// Reset: asynchronous, clears mode, targets, errors, powers and counters.
module pose_settle_controller_unit #(
	parameter int COUNTER_WIDTH = psc_pkg::CounterWidthDef,
	parameter int POSITION_WIDTH = psc_pkg::PositionWidthDef
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  psc_pkg::in_item_t in_data,
	output logic out_valid,
	input  logic out_ready,
	output psc_pkg::out_item_t out_data,
	input  logic cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [22:0] cfg_wdata
);
	localparam int EW = POSITION_WIDTH + 1;
	localparam int CW = COUNTER_WIDTH;
	localparam int LW = (EW + 17 > 42) ? EW + 17 : 42;
	localparam int TW = ((EW > 23) ? EW : 23) + 1;
	localparam int KW = ((CW > 16) ? CW : 16) + 1;

	typedef enum logic [7:0] {
		S_IDLE  = 8'b00000001,
		S_ERR   = 8'b00000010,
		S_MUL   = 8'b00000100,
		S_HPMUL = 8'b00001000,
		S_CMD   = 8'b00010000,
		S_SETL  = 8'b00100000,
		S_DIV   = 8'b01000000,
		S_OUT   = 8'b10000000
	} state_t;

	state_t state_q;
	logic [15:0] xg_q, yg_q, hg_q, sc_q;
	logic [14:0] ls_q, hs_q;
	logic [22:0] lt_q, ht_q;

	logic [1:0] mode_q;
	logic signed [POSITION_WIDTH-1:0] tgt_q [3];
	logic signed [EW-1:0] err_q [3];
	logic [1:0] lp_q;
	logic [16:0] hp_q;
	logic [CW-1:0] cnt_q [3];
	logic signed [15:0] turn_q;

	psc_pkg::in_item_t it_q;
	logic [1:0] ax_q;
	logic [40:0] mag_q [3];
	logic signed [15:0] cx_q, cy_q;
	logic valid_q, reached_q;
	logic signed [15:0] dx_q, dy_q, dt_q;
	// divider
	logic [CW+16:0] rem_q;
	logic [CW+16:0] quo_q;
	logic [5:0] dstep_q;

	logic ovalid_q;
	psc_pkg::out_item_t odata_q;

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = ovalid_q;
	assign out_data = odata_q;

	// config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xg_q <= 16'd256; yg_q <= 16'd256; hg_q <= 16'd256;
			ls_q <= '0; hs_q <= '0; lt_q <= 23'd10; ht_q <= 23'd100; sc_q <= 16'd10;
		end else if (cfg_we) begin
			case (cfg_index)
				psc_pkg::REG_X_GAIN: xg_q <= cfg_wdata[15:0];
				psc_pkg::REG_Y_GAIN: yg_q <= cfg_wdata[15:0];
				psc_pkg::REG_H_GAIN: hg_q <= cfg_wdata[15:0];
				psc_pkg::REG_L_STATIC: ls_q <= cfg_wdata[14:0];
				psc_pkg::REG_H_STATIC: hs_q <= cfg_wdata[14:0];
				psc_pkg::REG_L_TOL: lt_q <= cfg_wdata;
				psc_pkg::REG_H_TOL: ht_q <= cfg_wdata;
				psc_pkg::REG_SETTLE: sc_q <= cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	// shared multiplier: magnitude of error times gain per axis; a separate product of heading mag times power
	logic [EW-1:0] abs_e;
	logic [15:0] gsel;
	logic [14:0] ksel;
	logic [40:0] mul_law;
	logic [57:0] hp_prod;
	logic [LW-1:0] law_sum;
	always_comb begin
		abs_e = err_q[ax_q][EW-1] ? EW'(-err_q[ax_q]) : EW'(err_q[ax_q]);
		case (ax_q)
			2'd0: begin gsel = xg_q; ksel = ls_q; end
			2'd1: begin gsel = yg_q; ksel = ls_q; end
			default: begin gsel = hg_q; ksel = hs_q; end
		endcase
		law_sum = LW'(abs_e) * LW'(gsel) + LW'({ksel, 8'd0});
		mul_law = (law_sum > LW'(42'h100_0000_0000)) ? 41'h100_0000_0000 : law_sum[40:0];
		hp_prod = 58'(mag_q[2]) * 58'(hp_q);
	end

	function automatic logic signed [15:0] lincmd(input logic signed [EW-1:0] e,
			input logic [40:0] m, input logic p);
		logic signed [42:0] v;
		v = 43'($signed({2'b00, m[40:8]}));
		if (!p || e == 0) return 16'sd0;
		return psc_pkg::sat16(e < 0 ? v : -v);
	endfunction

	function automatic logic below_tol(input logic signed [EW-1:0] e,
			input logic [22:0] tol);
		logic [EW-1:0] a;
		a = e[EW-1] ? EW'(-e) : EW'(e);
		return TW'(a) < TW'(tol);
	endfunction

	logic [EW-1:0] abs_a;
	logic [22:0] tol_a;
	logic lt_tol, gt_tol;
	logic [CW-1:0] cnt_inc;
	always_comb begin
		abs_a = err_q[ax_q][EW-1] ? EW'(-err_q[ax_q]) : EW'(err_q[ax_q]);
		tol_a = (ax_q == 2'd2) ? ht_q : lt_q;
		lt_tol = TW'(abs_a) < TW'(tol_a);
		gt_tol = TW'(abs_a) > TW'(tol_a);
		cnt_inc = cnt_q[ax_q] + CW'(1);
	end

	logic [CW+16:0] trial;
	assign trial = {rem_q[CW+15:0], quo_q[CW+16]} - (CW+17)'(sc_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			mode_q <= psc_pkg::MODE_TELEOP;
			for (int i = 0; i < 3; i++) begin
				tgt_q[i] <= '0; err_q[i] <= '0; cnt_q[i] <= '0;
			end
			lp_q <= '0; hp_q <= '0; turn_q <= '0;
			ovalid_q <= 1'b0;
			ax_q <= '0;
		end else begin
			if (out_valid && out_ready && state_q != S_OUT) ovalid_q <= 1'b0;
			case (state_q)
				S_IDLE: if (in_valid) begin
					it_q <= in_data;
					valid_q <= (in_data.op == psc_pkg::OP_TICK) && !in_data.enabled;
					reached_q <= 1'b0;
					dx_q <= '0; dy_q <= '0; dt_q <= '0;
					case (in_data.op)
						psc_pkg::OP_POSE: begin
							tgt_q[0] <= POSITION_WIDTH'(in_data.goal_x);
							tgt_q[1] <= POSITION_WIDTH'(in_data.goal_y);
							tgt_q[2] <= POSITION_WIDTH'(in_data.goal_heading);
							mode_q <= psc_pkg::MODE_AUTO;
							lp_q <= 2'b11; hp_q <= 17'h10000;
							state_q <= S_OUT;
						end
						psc_pkg::OP_HEAD: begin
							tgt_q[2] <= POSITION_WIDTH'(in_data.goal_heading);
							mode_q <= psc_pkg::MODE_HEAD;
							hp_q <= 17'h10000;
							state_q <= S_OUT;
						end
						psc_pkg::OP_TICK: state_q <= S_ERR;
						default: state_q <= S_OUT;
					endcase
				end
				S_ERR: begin
					if (mode_q == psc_pkg::MODE_HEAD || mode_q == psc_pkg::MODE_AUTO)
						err_q[2] <= EW'(tgt_q[2]) - EW'(POSITION_WIDTH'(it_q.pos_yaw));
					if (mode_q == psc_pkg::MODE_AUTO) begin
						err_q[0] <= EW'(tgt_q[0]) - EW'(POSITION_WIDTH'(it_q.pos_x));
						err_q[1] <= EW'(tgt_q[1]) - EW'(POSITION_WIDTH'(it_q.pos_y));
					end
					ax_q <= 2'd0;
					state_q <= S_MUL;
				end
				S_MUL: begin
					mag_q[ax_q] <= (err_q[ax_q] == 0) ? 41'd0 : mul_law;
					if (ax_q == 2'd2) state_q <= S_HPMUL;
					else ax_q <= ax_q + 2'd1;
				end
				S_HPMUL: begin
					if (mode_q == psc_pkg::MODE_HEAD || mode_q == psc_pkg::MODE_AUTO)
						turn_q <= psc_pkg::sat16(err_q[2] < 0 ?
							-$signed({9'd0, hp_prod[57:24]}) :
							$signed({9'd0, hp_prod[57:24]}));
					cx_q <= lincmd(err_q[0], mag_q[0], lp_q[0]);
					cy_q <= lincmd(err_q[1], mag_q[1], lp_q[1]);
					state_q <= S_CMD;
				end
				S_CMD: begin
					ax_q <= 2'd2;
					if (mode_q == psc_pkg::MODE_AUTO && lp_q == 2'b00 && hp_q == '0) begin
						lp_q <= 2'b11; hp_q <= 17'h10000;
					end
					if (mode_q == psc_pkg::MODE_AUTO && lp_q == 2'b00 && hp_q == '0 &&
						below_tol(err_q[2], ht_q) && below_tol(err_q[1], lt_q) &&
						below_tol(err_q[0], lt_q)) begin
						// goal reached: report the stop and skip the counter update
						mode_q <= psc_pkg::MODE_TELEOP;
						valid_q <= 1'b1; reached_q <= 1'b1;
						dx_q <= '0; dy_q <= '0; dt_q <= '0;
						state_q <= S_OUT;
					end else begin
						state_q <= S_SETL;
						if (mode_q == psc_pkg::MODE_AUTO && it_q.enabled && it_q.autonomous) begin
							valid_q <= 1'b1;
							dx_q <= cx_q; dy_q <= cy_q; dt_q <= turn_q;
						end
					end
				end
				S_SETL: begin
					// axes in order heading, x, y
					if (lt_tol) begin
						if (KW'(cnt_inc) > KW'(sc_q)) begin
							if (ax_q == 2'd2) hp_q <= '0; else lp_q[ax_q[0]] <= 1'b0;
							cnt_q[ax_q] <= '0;
						end else begin
							cnt_q[ax_q] <= cnt_inc;
							if (ax_q == 2'd2) begin
								rem_q <= '0;
								quo_q <= {1'b0, cnt_inc, 16'd0};
								dstep_q <= '0;
							end
						end
					end else if (gt_tol) cnt_q[ax_q] <= '0;
					if (ax_q == 2'd2 && lt_tol && KW'(cnt_inc) <= KW'(sc_q)) begin
						if (sc_q == '0) begin
							hp_q <= '0; ax_q <= 2'd0;
						end else state_q <= S_DIV;
					end else if (ax_q == 2'd2) ax_q <= 2'd0;
					else if (ax_q == 2'd0) ax_q <= 2'd1;
					else state_q <= S_OUT;
				end
				S_DIV: begin
					// restoring division, one quotient bit per cycle
					if (!trial[CW+16]) begin
						rem_q <= trial;
						quo_q <= {quo_q[CW+15:0], 1'b1};
					end else begin
						rem_q <= {rem_q[CW+15:0], quo_q[CW+16]};
						quo_q <= {quo_q[CW+15:0], 1'b0};
					end
					dstep_q <= dstep_q + 6'd1;
					if (dstep_q == 6'(CW + 16)) begin
						hp_q <= 17'(18'h10000 - 18'({quo_q[CW+15:0],
							!trial[CW+16]} & (CW+17)'(18'h3ffff)));
						ax_q <= 2'd0;
						state_q <= S_SETL;
					end
				end
				S_OUT: if (!ovalid_q || out_ready) begin
					ovalid_q <= 1'b1;
					odata_q.drive_valid <= valid_q;
					odata_q.drive_x <= dx_q;
					odata_q.drive_y <= dy_q;
					odata_q.drive_turn <= dt_q;
					odata_q.goal_reached <= reached_q;
					odata_q.mode_now <= mode_q;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> state_q == S_IDLE) else $error("ready outside idle");
	a_reach_stop: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.goal_reached) |-> (out_data.drive_valid &&
		out_data.mode_now == psc_pkg::MODE_TELEOP)) else $error("reach without stop");
	a_hp_range: assert property (@(posedge clk) disable iff (!arst_n)
		hp_q <= 17'h10000) else $error("heading power above one");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready) else $error("ready after accept");
endmodule

@@ bench/psc_checker.sv @@
// Checker: watches the request and result channels and the register port, predicts each result and compares.
`timescale 1ns / 1ps

module psc_checker (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_ready,
	input  psc_pkg::in_item_t in_data,
	input  logic out_valid,
	input  logic out_ready,
	input  psc_pkg::out_item_t out_data,
	input  logic cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [22:0] cfg_wdata,
	output int errors,
	output int pending,
	output int results_seen,
	output int goals_seen
);

	// register copies
	longint unsigned kp_x, kp_y, kp_h, ks_lin, ks_head, tol_lin, tol_head, settle_lim;

	// controller state copy
	logic [1:0] mode_q;
	longint target_q [3];
	longint err_q [3];
	bit lin_pow [2];
	longint unsigned head_pow;
	longint unsigned settle_cnt [3];
	logic signed [15:0] turn_q;

	psc_pkg::out_item_t drive_fifo [$];

	function automatic longint unsigned abs_of(longint e);
		return (e < 0) ? longint'(-e) : longint'(e);
	endfunction

	function automatic logic signed [15:0] clip16(longint v);
		if (v > 32767) return 16'sh7fff;
		if (v < -32768) return 16'sh8000;
		return v[15:0];
	endfunction

	function automatic longint unsigned law_mag(longint e, longint unsigned ks,
			longint unsigned kp);
		longint unsigned m;
		if (e == 0) return 0;
		m = ks * 256 + abs_of(e) * kp;
		if (m > (64'd1 << 40)) m = 64'd1 << 40;
		return m;
	endfunction

	function automatic longint apply_sign(longint e, longint unsigned m);
		return (e < 0) ? -longint'(m) : longint'(m);
	endfunction

	function automatic void settle_axis(int a, longint unsigned tol);
		longint unsigned e;
		e = abs_of(err_q[a]);
		if (e < tol) begin
			settle_cnt[a] = (settle_cnt[a] + 1) & 64'hffff;
			if (settle_cnt[a] > settle_lim) begin
				if (a < 2) lin_pow[a] = 0;
				else head_pow = 0;
				settle_cnt[a] = 0;
			end else if (a == 2) begin
				head_pow = (settle_lim != 0) ?
					65536 - (settle_cnt[a] * 65536) / settle_lim : 0;
			end
		end else if (e > tol) begin
			settle_cnt[a] = 0;
		end
	endfunction

	function automatic psc_pkg::out_item_t drive_step(psc_pkg::in_item_t it);
		psc_pkg::out_item_t r;
		longint pos [3];
		longint ex, ey, eh, cx, cy;
		bit done;
		r = '0;
		done = 0;
		pos[0] = it.pos_x;
		pos[1] = it.pos_y;
		pos[2] = it.pos_yaw;
		case (it.op)
			psc_pkg::OP_POSE: begin
				target_q[0] = it.goal_x;
				target_q[1] = it.goal_y;
				target_q[2] = it.goal_heading;
				mode_q = psc_pkg::MODE_AUTO;
				lin_pow[0] = 1;
				lin_pow[1] = 1;
				head_pow = 65536;
			end
			psc_pkg::OP_HEAD: begin
				target_q[2] = it.goal_heading;
				mode_q = psc_pkg::MODE_HEAD;
				head_pow = 65536;
			end
			psc_pkg::OP_TICK: begin
				if (!it.enabled) r.drive_valid = 1;
				if (mode_q == psc_pkg::MODE_HEAD || mode_q == psc_pkg::MODE_AUTO) begin
					eh = target_q[2] - pos[2];
					err_q[2] = eh;
					turn_q = clip16(apply_sign(eh,
						(law_mag(eh, ks_head, kp_h) * head_pow) >> 24));
				end
				if (mode_q == psc_pkg::MODE_AUTO) begin
					ex = target_q[0] - pos[0];
					ey = target_q[1] - pos[1];
					err_q[0] = ex;
					err_q[1] = ey;
					cx = lin_pow[0] ? apply_sign(ex, law_mag(ex, ks_lin, kp_x) >> 8) : 0;
					cy = lin_pow[1] ? apply_sign(ey, law_mag(ey, ks_lin, kp_y) >> 8) : 0;
					if (it.enabled && it.autonomous) begin
						r.drive_valid = 1;
						r.drive_x = clip16(-cx);
						r.drive_y = clip16(-cy);
						r.drive_turn = turn_q;
					end
					if (!lin_pow[0] && !lin_pow[1] && head_pow == 0) begin
						lin_pow[0] = 1;
						lin_pow[1] = 1;
						head_pow = 65536;
						if (abs_of(err_q[2]) < tol_head && abs_of(ey) < tol_lin &&
								abs_of(ex) < tol_lin) begin
							mode_q = psc_pkg::MODE_TELEOP;
							r.drive_valid = 1;
							r.drive_x = 0;
							r.drive_y = 0;
							r.drive_turn = 0;
							r.goal_reached = 1;
							done = 1;
						end
					end
				end
				if (!done) begin
					settle_axis(2, tol_head);
					settle_axis(0, tol_lin);
					settle_axis(1, tol_lin);
				end
			end
			default: ;
		endcase
		r.mode_now = mode_q;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		psc_pkg::out_item_t want;
		if (!arst_n) begin
			kp_x = 256; kp_y = 256; kp_h = 256;
			ks_lin = 0; ks_head = 0;
			tol_lin = 10; tol_head = 100; settle_lim = 10;
			mode_q = psc_pkg::MODE_TELEOP;
			for (int i = 0; i < 3; i++) begin
				target_q[i] = 0; err_q[i] = 0; settle_cnt[i] = 0;
			end
			lin_pow[0] = 0; lin_pow[1] = 0;
			head_pow = 0;
			turn_q = 0;
			drive_fifo.delete();
			errors = 0; results_seen = 0; goals_seen = 0;
		end else begin
			// compare before predicting: a result never belongs to the request of the same edge
			if (out_valid && out_ready) begin
				results_seen++;
				if (drive_fifo.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("%0t: result with no request pending: %p", $realtime, out_data);
				end else begin
					want = drive_fifo.pop_front();
					if (want.goal_reached) goals_seen++;
					if (out_data.drive_valid !== want.drive_valid ||
							out_data.drive_x !== want.drive_x ||
							out_data.drive_y !== want.drive_y ||
							out_data.drive_turn !== want.drive_turn ||
							out_data.goal_reached !== want.goal_reached ||
							out_data.mode_now !== want.mode_now) begin
						errors++;
						if (errors <= 10)
							$display("%0t: mismatch expected %p actual %p",
								$realtime, want, out_data);
					end
				end
			end
			if (in_valid && in_ready) drive_fifo.push_back(drive_step(in_data));
			if (cfg_we) begin
				case (cfg_index)
					psc_pkg::REG_X_GAIN: kp_x = cfg_wdata[15:0];
					psc_pkg::REG_Y_GAIN: kp_y = cfg_wdata[15:0];
					psc_pkg::REG_H_GAIN: kp_h = cfg_wdata[15:0];
					psc_pkg::REG_L_STATIC: ks_lin = cfg_wdata[14:0];
					psc_pkg::REG_H_STATIC: ks_head = cfg_wdata[14:0];
					psc_pkg::REG_L_TOL: tol_lin = cfg_wdata;
					psc_pkg::REG_H_TOL: tol_head = cfg_wdata;
					psc_pkg::REG_SETTLE: settle_lim = cfg_wdata[15:0];
					default: ;
				endcase
			end
		end
		pending = drive_fifo.size();
	end

endmodule

@@ bench/tb_top.sv @@
// Testbench top: stimulus, register setup and verdict for the pose settle controller.
`timescale 1ns / 1ps

module tb_top;

	localparam int IDLE_LIMIT = 5000;

	logic clk;
	logic arst_n;
	logic in_valid, in_ready, out_valid, out_ready;
	psc_pkg::in_item_t in_data;
	psc_pkg::out_item_t out_data;
	logic cfg_we;
	logic [2:0] cfg_index;
	logic [22:0] cfg_wdata;
	int errors, pending, results_seen, goals_seen;
	int items_sent, idle_cycles, phase_cnt;
	bit calm;
	longint goal_x, goal_y, goal_h, near_span;

	pose_settle_controller_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	psc_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.errors(errors), .pending(pending),
		.results_seen(results_seen), .goals_seen(goals_seen)
	);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	function automatic int gap_len();
		if (calm) return 0;
		if ($urandom_range(0, 9) < 8) return $urandom_range(0, 3);
		return $urandom_range(10, 60);
	endfunction

	// receiver side: random stalls, occasionally long
	int stall_left;
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stall_left <= 0;
			out_ready <= 0;
		end else if (stall_left > 0) begin
			out_ready <= 0;
			stall_left <= stall_left - 1;
		end else begin
			out_ready <= 1;
			stall_left <= gap_len();
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic send_request(psc_pkg::in_item_t it);
		int g;
		@(negedge clk);
		in_valid <= 1;
		in_data <= it;
		do @(posedge clk); while (!in_ready);
		items_sent++;
		g = gap_len();
		if (g > 0) begin
			@(negedge clk);
			in_valid <= 0;
			repeat (g - 1) @(negedge clk);
		end
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid <= 0;
		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [22:0] val);
		@(negedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 0;
	endtask

	task automatic write_all(logic [15:0] kx, logic [15:0] ky, logic [15:0] kh,
			logic [14:0] sl, logic [14:0] sh, logic [22:0] tl, logic [22:0] th,
			logic [15:0] st);
		write_reg(psc_pkg::REG_X_GAIN, 23'(kx));
		write_reg(psc_pkg::REG_Y_GAIN, 23'(ky));
		write_reg(psc_pkg::REG_H_GAIN, 23'(kh));
		write_reg(psc_pkg::REG_L_STATIC, 23'(sl));
		write_reg(psc_pkg::REG_H_STATIC, 23'(sh));
		write_reg(psc_pkg::REG_L_TOL, tl);
		write_reg(psc_pkg::REG_H_TOL, th);
		write_reg(psc_pkg::REG_SETTLE, 23'(st));
		near_span = (tl > th ? tl : th) * 2 + 2;
		if (near_span > 2000) near_span = 2000;
	endtask

	function automatic psc_pkg::in_item_t make_tick(logic en, logic am, longint px,
			longint py, longint ph);
		psc_pkg::in_item_t it;
		it = '0;
		it.op = psc_pkg::OP_TICK;
		it.enabled = en;
		it.autonomous = am;
		it.pos_x = px[23:0];
		it.pos_y = py[23:0];
		it.pos_yaw = ph[23:0];
		return it;
	endfunction

	function automatic longint near(longint c);
		return c + longint'($urandom_range(0, 2 * near_span)) - near_span;
	endfunction

	function automatic psc_pkg::in_item_t random_request();
		psc_pkg::in_item_t it;
		logic [159:0] raw;
		int r;
		raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
		it = raw[$bits(psc_pkg::in_item_t)-1:0];
		r = $urandom_range(0, 99);
		if (r < 4) begin
			it.op = psc_pkg::OP_POSE;
			if ($urandom_range(0, 3) != 0) begin
				it.goal_x = 24'($signed($urandom_range(0, 4000)) - 2000);
				it.goal_y = 24'($signed($urandom_range(0, 4000)) - 2000);
				it.goal_heading = 24'($signed($urandom_range(0, 36000)) - 18000);
			end
			goal_x = it.goal_x;
			goal_y = it.goal_y;
			goal_h = it.goal_heading;
		end else if (r < 6) begin
			it.op = psc_pkg::OP_HEAD;
			goal_h = it.goal_heading;
		end else if (r < 7) begin
			it.op = psc_pkg::OP_UNUSED;
		end else begin
			it.op = psc_pkg::OP_TICK;
			it.enabled = ($urandom_range(0, 9) != 0);
			it.autonomous = ($urandom_range(0, 9) != 0);
			if ($urandom_range(0, 3) != 0) begin
				it.pos_x = near(goal_x);
				it.pos_y = near(goal_y);
				it.pos_yaw = near(goal_h);
			end
		end
		return it;
	endfunction

	initial begin
		psc_pkg::in_item_t it;
		arst_n = 0;
		in_valid = 0;
		in_data = '0;
		cfg_we = 0;
		cfg_index = '0;
		cfg_wdata = '0;
		items_sent = 0;
		calm = 0;
		goal_x = 0; goal_y = 0; goal_h = 0;
		near_span = 202;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: ticks before any goal, in teleop
		send_request(make_tick(1, 1, 0, 0, 0));
		send_request(make_tick(0, 1, 5, 5, 5));
		// extreme errors, saturating commands at reset gains
		it = '0;
		it.op = psc_pkg::OP_POSE;
		it.goal_x = 24'h7fffff;
		it.goal_y = 24'h800000;
		it.goal_heading = 24'h7fffff;
		send_request(it);
		send_request(make_tick(1, 1, -8388608, 8388607, -8388608));
		send_request(make_tick(1, 0, -8388608, 8388607, -8388608));
		send_request(make_tick(0, 1, 0, 0, 0));
		it.op = psc_pkg::OP_UNUSED;
		send_request(it);
		drain();
		write_all(16'hffff, 16'hffff, 16'hffff, 15'h7fff, 15'h7fff, 23'd0, 23'd0, 16'd2);
		send_request(make_tick(1, 1, 8388607, -8388608, 8388607));
		// heading-only mode
		it = '0;
		it.op = psc_pkg::OP_HEAD;
		it.goal_heading = 24'sd100;
		send_request(it);
		send_request(make_tick(1, 1, 0, 0, 0));
		send_request(make_tick(1, 1, 0, 0, 100));
		drain();
		// settle to a goal at the origin with zero error
		write_all(16'd256, 16'd512, 16'd128, 15'd10, 15'd20, 23'd10, 23'd100, 16'd2);
		it = '0;
		it.op = psc_pkg::OP_POSE;
		send_request(it);
		repeat (6) send_request(make_tick(1, 1, 0, 0, 0));
		send_request(make_tick(1, 1, 3, -3, 50));
		drain();

		for (phase_cnt = 0; phase_cnt < 6; phase_cnt++) begin
			case (phase_cnt)
				0: write_all(16'd256, 16'd256, 16'd256, 15'd0, 15'd0, 23'd10, 23'd100,
					16'd3);
				1: write_all(16'hffff, 16'd0, 16'hffff, 15'h7fff, 15'h7fff, 23'd0, 23'd0,
					16'd1);
				2: write_all(16'd0, 16'hffff, 16'd0, 15'd0, 15'd0, 23'h7fffff,
					23'h7fffff, 16'd1);
				3: write_all(16'd300, 16'd40, 16'd900, 15'd50, 15'd7, 23'd20, 23'd300,
					16'hffff);
				default: write_all(16'($urandom), 16'($urandom), 16'($urandom),
					15'($urandom), 15'($urandom), 23'($urandom_range(0, 400)),
					23'($urandom_range(0, 800)), 16'($urandom_range(1, 6)));
			endcase
			calm = (phase_cnt == 4);
			for (int n = 0; n < 300; n++) begin
				if (phase_cnt == 3 && n == 150) drain();
				send_request(random_request());
			end
			drain();
		end

		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		$display("Run covered %0d requests over %0d register settings, %0d results checked.",
			items_sent, 9, results_seen);
		$display("Goals reached: %0d; mismatches: %0d.", goals_seen, errors);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

@@ pose_settle_controller_unit.f @@
hw/rtl/psc_pkg.sv
hw/rtl/pose_settle_controller_unit.sv
bench/psc_checker.sv
bench/tb_top.sv
